// File: hdl/swhc_pkg.sv
`timescale 1ns / 1ps

package swhc_pkg;

  // One input word: a sample of each series and the end-of-window mark.
  typedef struct packed {
    logic               window_end;
    logic signed [15:0] accel_sample;
    logic signed [15:0] temperature_decidegrees;
    logic [15:0]        voltage_mv;
  } sample_t;

  // Closed window as handed from the accumulator to the verdict stage.
  typedef struct packed {
    logic               missing_data;
    logic               minor_resolution;
    logic [1:0]         square_code;
    logic [1:0]         outlier_code;
    logic               drift_flag;
    logic               rotation_flag;
    logic [10:0]        samples_seen;
    logic signed [15:0] temp_min;
    logic signed [15:0] temp_max;
    logic signed [15:0] accel_min;
    logic signed [15:0] accel_max;
  } snap_t;

  localparam int SAMPLE_W = 48;
  localparam int RESULT_W = 24;

  // Register map, selected by paddr[2].
  localparam logic REG_RATE     = 1'b0;
  localparam logic REG_DURATION = 1'b1;

  // Step thresholds on absolute differences.
  localparam logic [16:0] STEP_SMALL = 17'd3;
  localparam logic [16:0] STEP_DRIFT = 17'd100;
  localparam logic [16:0] STEP_JUMP  = 17'd300;
  localparam logic [16:0] STEP_ROT   = 17'd2048;

  localparam logic signed [15:0] COLD_LIMIT  = -16'sd200;
  localparam logic signed [15:0] SAT_INNER   = 16'sd5632;
  localparam logic signed [15:0] SAT_OUTER   = 16'sd6656;
  localparam logic signed [16:0] ACTIVE_SPAN = 17'sd5120;

  localparam logic [1:0] RUN_FULL = 2'd3;

  localparam logic [1:0] SQ_NONE = 2'd0;
  localparam logic [1:0] SQ_HIGH = 2'd1;
  localparam logic [1:0] SQ_LOW  = 2'd2;

  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_COLD = 2'd1;
  localparam logic [1:0] OUT_JUMP = 2'd2;

  localparam logic [1:0] TR_NONE   = 2'd0;
  localparam logic [1:0] TR_TEMP   = 2'd1;
  localparam logic [1:0] TR_ACTIVE = 2'd2;

endpackage

// File: hdl/swhc_window.sv
`timescale 1ns / 1ps

module swhc_window #(
  parameter int WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  swhc_pkg::sample_t in_item,
  output logic             in_ready,
  input  logic [31:0]      expected,
  output logic             snap_valid,
  output swhc_pkg::snap_t  snap,
  input  logic             out_ready
);
  import swhc_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] WINDOW_C = CW'(WINDOW);

  logic [CW-1:0]      sample_count, count_next;
  logic [CW-1:0]      small_step_count, small_next;
  logic signed [15:0] temp_min, temp_max, accel_min, accel_max;
  logic signed [15:0] tmin_next, tmax_next, amin_next, amax_next;
  logic [15:0]        prev_voltage;
  logic signed [15:0] prev_accel;
  logic [1:0]         high_run, low_run, square_latch, last_outlier;
  logic [1:0]         high_next, low_next, square_next, outlier_next;
  logic [1:0]         event_flags, events_next;

  logic               accept, take, first, cold, hi_band, lo_band;
  logic [16:0]        dv_raw, da_raw, dv, da;
  logic [CW+2:0]      five_small, four_steps;
  logic               minor;

  assign in_ready = !in_item.window_end || !snap_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign take     = accept && (sample_count < WINDOW_C);
  assign first    = (sample_count == '0);

  always_comb begin
    dv_raw  = {1'b0, in_item.voltage_mv} - {1'b0, prev_voltage};
    da_raw  = {in_item.accel_sample[15], in_item.accel_sample}
            - {prev_accel[15], prev_accel};
    dv      = dv_raw[16] ? (17'd0 - dv_raw) : dv_raw;
    da      = da_raw[16] ? (17'd0 - da_raw) : da_raw;
    cold    = in_item.temperature_decidegrees <= COLD_LIMIT;
    hi_band = (in_item.accel_sample >= SAT_INNER) && (in_item.accel_sample <= SAT_OUTER);
    lo_band = (in_item.accel_sample >= -SAT_OUTER) && (in_item.accel_sample <= -SAT_INNER);

    count_next   = sample_count;
    small_next   = small_step_count;
    tmin_next    = temp_min;
    tmax_next    = temp_max;
    amin_next    = accel_min;
    amax_next    = accel_max;
    high_next    = high_run;
    low_next     = low_run;
    square_next  = square_latch;
    outlier_next = last_outlier;
    events_next  = event_flags;

    if (take) begin
      count_next = sample_count + CW'(1);
      if (first) begin
        tmin_next    = in_item.temperature_decidegrees;
        tmax_next    = in_item.temperature_decidegrees;
        amin_next    = in_item.accel_sample;
        amax_next    = in_item.accel_sample;
        outlier_next = cold ? OUT_COLD : OUT_NONE;
      end else begin
        if (in_item.temperature_decidegrees < temp_min) begin
          tmin_next = in_item.temperature_decidegrees;
        end
        if (in_item.temperature_decidegrees > temp_max) begin
          tmax_next = in_item.temperature_decidegrees;
        end
        if (in_item.accel_sample < accel_min) begin
          amin_next = in_item.accel_sample;
        end
        if (in_item.accel_sample > accel_max) begin
          amax_next = in_item.accel_sample;
        end
        if (dv > STEP_DRIFT) begin
          events_next[0] = 1'b1;
        end
        if (da > STEP_ROT) begin
          events_next[1] = 1'b1;
        end
        if (da <= STEP_SMALL) begin
          small_next = small_step_count + CW'(1);
        end
        priority if (cold) begin
          outlier_next = OUT_COLD;
        end else if (dv > STEP_JUMP) begin
          outlier_next = OUT_JUMP;
        end else begin
          outlier_next = OUT_NONE;
        end
      end
      priority if (hi_band) begin
        high_next = (high_run == RUN_FULL) ? RUN_FULL : high_run + 2'd1;
        low_next  = 2'd0;
      end else if (lo_band) begin
        low_next  = (low_run == RUN_FULL) ? RUN_FULL : low_run + 2'd1;
        high_next = 2'd0;
      end else begin
        high_next = 2'd0;
        low_next  = 2'd0;
      end
      if (square_latch == SQ_NONE) begin
        priority if (high_next == RUN_FULL) begin
          square_next = SQ_HIGH;
        end else if (low_next == RUN_FULL) begin
          square_next = SQ_LOW;
        end else begin
          square_next = SQ_NONE;
        end
      end
    end

    // At least 80 percent of the steps are small: 5*small >= 4*(n-1).
    five_small = {1'b0, small_next, 2'b00} + (CW+3)'(small_next);
    four_steps = {1'b0, count_next - CW'(1), 2'b00};
    minor      = (count_next >= CW'(2)) && (five_small >= four_steps);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= '0;
      small_step_count <= '0;
      temp_min         <= '0;
      temp_max         <= '0;
      accel_min        <= '0;
      accel_max        <= '0;
      prev_voltage     <= '0;
      prev_accel       <= '0;
      high_run         <= '0;
      low_run          <= '0;
      square_latch     <= SQ_NONE;
      last_outlier     <= OUT_NONE;
      event_flags      <= '0;
      snap_valid       <= 1'b0;
    end else begin
      if (accept && in_item.window_end) begin
        sample_count     <= '0;
        small_step_count <= '0;
        temp_min         <= '0;
        temp_max         <= '0;
        accel_min        <= '0;
        accel_max        <= '0;
        prev_voltage     <= '0;
        prev_accel       <= '0;
        high_run         <= '0;
        low_run          <= '0;
        square_latch     <= SQ_NONE;
        last_outlier     <= OUT_NONE;
        event_flags      <= '0;
      end else if (take) begin
        sample_count     <= count_next;
        small_step_count <= small_next;
        temp_min         <= tmin_next;
        temp_max         <= tmax_next;
        accel_min        <= amin_next;
        accel_max        <= amax_next;
        prev_voltage     <= in_item.voltage_mv;
        prev_accel       <= in_item.accel_sample;
        high_run         <= high_next;
        low_run          <= low_next;
        square_latch     <= square_next;
        last_outlier     <= outlier_next;
        event_flags      <= events_next;
      end
      if (accept && in_item.window_end) begin
        snap_valid <= 1'b1;
      end else if (out_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.window_end) begin
      snap.missing_data     <= {{(32-CW){1'b0}}, count_next} < expected;
      snap.minor_resolution <= minor;
      snap.square_code      <= square_next;
      snap.outlier_code     <= outlier_next;
      snap.drift_flag       <= events_next[0];
      snap.rotation_flag    <= events_next[1];
      snap.samples_seen     <= 11'(count_next);
      snap.temp_min         <= tmin_next;
      snap.temp_max         <= tmax_next;
      snap.accel_min        <= amin_next;
      snap.accel_max        <= amax_next;
    end
  end

endmodule

// File: hdl/swhc_verdict.sv
`timescale 1ns / 1ps

module swhc_verdict (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              snap_valid,
  input  swhc_pkg::snap_t                   snap,
  output logic                              out_ready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swhc_pkg::RESULT_W-1:0]     m_tdata
);
  import swhc_pkg::*;

  logic [15:0]        temp_span;
  logic [19:0]        temp_span_x10;
  logic [19:0]        temp_min_x3;
  logic signed [16:0] accel_span;
  logic [1:0]         trend;

  assign out_ready = !m_tvalid || m_tready;

  always_comb begin
    // Only read when the minimum is not negative, so both ends are.
    temp_span     = 16'(snap.temp_max - snap.temp_min);
    temp_span_x10 = {1'b0, temp_span, 3'b000} + {3'b000, temp_span, 1'b0};
    temp_min_x3   = {4'b0, snap.temp_min[14:0], 1'b0} + {5'b0, snap.temp_min[14:0]};
    accel_span    = {snap.accel_max[15], snap.accel_max} - {snap.accel_min[15], snap.accel_min};
    priority if (!snap.temp_min[15] && (temp_span_x10 > temp_min_x3)) begin
      trend = TR_TEMP;
    end else if (accel_span >= ACTIVE_SPAN) begin
      trend = TR_ACTIVE;
    end else begin
      trend = TR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && snap_valid) begin
      m_tdata <= {3'b000, snap.samples_seen, snap.rotation_flag, snap.drift_flag, trend,
                  snap.outlier_code, snap.square_code, snap.minor_resolution,
                  snap.missing_data};
    end
  end

endmodule

// File: hdl/sensor_window_health_checker.sv
`timescale 1ns / 1ps

// Sensor window health checker. Each input word carries one voltage sample (mV),
// one temperature sample (0.1 C, signed) and one acceleration sample (1/1024 g,
// signed); s_tlast marks the last sample of a window, and only that word yields a
// result word of health flags. The block takes one word per clock cycle, and a
// finished result may wait on m_tready while new samples keep flowing in; only a
// closing word stalls, while the single pending result slot in front of the output
// register is full and the output does not drain. A closing sample passes through
// the input register, then updates the window accumulator and its closing snapshot,
// and then loads the verdict register that evaluates the trend compares, which
// raises m_tvalid. Samples beyond WINDOW in one window are ignored, but s_tlast
// still closes the window. The expected sample count (rate times duration) is a
// registered product and follows a register write in the cycle after it.
module sensor_window_health_checker #(
  parameter int WINDOW = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] voltage_mv, [31:16] temperature_decidegrees, [47:32] accel_sample
  input  logic [47:0] s_tdata,
  input  logic        s_tlast,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] missing_data, [1] minor_resolution, [3:2] square_code, [5:4] outlier_code,
  // [7:6] trend_code, [8] drift_flag, [9] rotation_flag, [20:10] samples_seen,
  // [23:21] zero
  output logic [23:0] m_tdata
);
  import swhc_pkg::*;

  logic [15:0] sample_rate_hz;
  logic [15:0] duration_seconds;
  logic [31:0] expected;

  logic        cfg_write;

  logic        in_valid;
  sample_t     in_item;
  logic        win_ready;

  logic        snap_valid;
  snap_t       snap;
  logic        out_ready;

  // Configuration registers. Writes land on the access cycle; reads are plain muxes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz   <= '0;
      duration_seconds <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RATE:     sample_rate_hz   <= pwdata[15:0];
        REG_DURATION: duration_seconds <= pwdata[15:0];
        default:      sample_rate_hz   <= sample_rate_hz;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RATE:     prdata = {16'b0, sample_rate_hz};
      REG_DURATION: prdata = {16'b0, duration_seconds};
      default:      prdata = '0;
    endcase
  end

  // The expected count only changes with configuration, so its product is
  // computed once into a register rather than in the sample path.
  always_ff @(posedge clk) begin
    expected <= {16'b0, sample_rate_hz} * {16'b0, duration_seconds};
  end

  // Input register. It empties whenever the accumulator takes its word, so a
  // new word can enter in the same cycle.
  assign s_tready = !in_valid || win_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.voltage_mv              <= s_tdata[15:0];
      in_item.temperature_decidegrees <= s_tdata[31:16];
      in_item.accel_sample            <= s_tdata[47:32];
      in_item.window_end              <= s_tlast;
    end
  end

  swhc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_ready   (win_ready),
    .expected   (expected),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_ready  (out_ready)
  );

  swhc_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_ready  (out_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // An accepted word always lands in the input register.
  a_input_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted word did not reach the input register");

  // A closing word that leaves the input register must produce a pending snapshot.
  a_close_snapshots: assert property (@(posedge clk) disable iff (rst)
    in_valid && win_ready && in_item.window_end |=> snap_valid)
    else $error("window closed without a snapshot");

  // The three coded fields never carry the unused code.
  a_codes_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:2] != 2'b11) && (m_tdata[5:4] != 2'b11) &&
                 (m_tdata[7:6] != 2'b11))
    else $error("result word carries an undefined code");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !snap_valid)
    else $error("result pending after reset");

endmodule
